// ----- sv/ldct_pkg.sv -----
`default_nettype none
package ldct_pkg;

  localparam int N = 8;
  localparam int NSAMP = N * N;
  localparam int IDX_W = 3;
  localparam int ADDR_W = 6;
  localparam int FRAC_BITS = 14;
  localparam int BASIS_W = 16;
  localparam int SAMPLE_W = 9;
  localparam int ROW_W = 28;
  localparam int ACC_W = 48;
  localparam int COEF_W = 11;
  localparam int LEVEL_SHIFT = 128;

  // Orthonormal DCT-II basis: round(c_u * cos((2k+1)u*pi/16) * 2^14).
  function automatic logic signed [BASIS_W-1:0] basis(input logic [IDX_W-1:0] u,
                                                       input logic [IDX_W-1:0] k);
    logic signed [BASIS_W-1:0] t [0:63];
    t = '{
      16'sd5793,  16'sd5793,  16'sd5793,  16'sd5793,
      16'sd5793,  16'sd5793,  16'sd5793,  16'sd5793,
      16'sd8035,  16'sd6811,  16'sd4551,  16'sd1598,
      -16'sd1598, -16'sd4551, -16'sd6811, -16'sd8035,
      16'sd7568,  16'sd3135,  -16'sd3135, -16'sd7568,
      -16'sd7568, -16'sd3135, 16'sd3135,  16'sd7568,
      16'sd6811,  -16'sd1598, -16'sd8035, -16'sd4551,
      16'sd4551,  16'sd8035,  16'sd1598,  -16'sd6811,
      16'sd5793,  -16'sd5793, -16'sd5793, 16'sd5793,
      16'sd5793,  -16'sd5793, -16'sd5793, 16'sd5793,
      16'sd4551,  -16'sd8035, 16'sd1598,  16'sd6811,
      -16'sd6811, -16'sd1598, 16'sd8035,  -16'sd4551,
      16'sd3135,  -16'sd7568, 16'sd7568,  -16'sd3135,
      -16'sd3135, 16'sd7568,  -16'sd7568, 16'sd3135,
      16'sd1598,  -16'sd4551, 16'sd6811,  -16'sd8035,
      16'sd8035,  -16'sd6811, 16'sd4551,  -16'sd1598
    };
    return t[{u, k}];
  endfunction

endpackage
`default_nettype wire

// ----- sv/ldct_front.sv -----
`default_nettype none
module ldct_front import ldct_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [7:0]          pixel_value,
  input  wire logic                busy,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic signed [SAMPLE_W-1:0] wr_data,
  output logic                     block_done
);

  logic [ADDR_W-1:0] fill_count;
  logic              take;

  assign take = start && !busy;
  assign wr_en = take;
  assign wr_addr = fill_count;
  assign wr_data = $signed({1'b0, pixel_value}) - SAMPLE_W'(LEVEL_SHIFT);
  assign block_done = take && (fill_count == ADDR_W'(NSAMP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (take) begin
      fill_count <= fill_count + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ldct_back.sv -----
`default_nettype none
module ldct_back import ldct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire logic signed [SAMPLE_W-1:0] wr_data,
  input  wire logic                  block_done,
  output logic                       busy,
  output logic                       valid,
  output logic signed [COEF_W-1:0]   coefficient,
  output logic [IDX_W-1:0]           freq_row,
  output logic [IDX_W-1:0]           freq_col,
  output logic                       block_last
);

  typedef enum logic [1:0] {IDLE, ROWS, COLS, DRAIN} state_t;

  logic signed [SAMPLE_W-1:0] sample_mem [0:NSAMP-1];
  logic signed [ROW_W-1:0]    row_mem [0:NSAMP-1];

  state_t state;
  logic [IDX_W-1:0] i_a, i_b, i_k;
  logic             go;
  logic [IDX_W-1:0] p_a, p_b, p_k;
  logic             p_go, p_first, p_last;
  state_t           p_state;
  logic signed [SAMPLE_W-1:0] s_rd;
  logic signed [ROW_W-1:0]    r_rd;
  logic signed [ACC_W-1:0]    prod;
  logic signed [ACC_W-1:0]    acc;
  logic [IDX_W-1:0] q_a, q_b;
  logic             q_go, q_last;
  state_t           q_state;
  logic signed [ACC_W-1:0] sum;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] qv;

  always_ff @(posedge clk) begin
    if (wr_en) sample_mem[wr_addr] <= wr_data;
  end

  // Sequencer: ROWS computes T[y][v]=sum_x B[v][x]s[y][x]; COLS X[u][v]=sum_y B[u][y]T[y][v].
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      i_a <= '0; i_b <= '0; i_k <= '0;
    end else begin
      unique case (state)
        IDLE: if (block_done) state <= ROWS;
        ROWS, COLS: begin
          i_k <= i_k + 1'b1;
          if (i_k == IDX_W'(N - 1)) begin
            i_b <= i_b + 1'b1;
            if (i_b == IDX_W'(N - 1)) begin
              i_a <= i_a + 1'b1;
              if (i_a == IDX_W'(N - 1)) state <= (state == ROWS) ? COLS : DRAIN;
            end
          end
        end
        DRAIN: if (!p_go && !q_go) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign go = (state == ROWS) || (state == COLS);
  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    s_rd <= sample_mem[{i_a, i_k}];
    r_rd <= row_mem[{i_k, i_b}];
    p_a <= i_a; p_b <= i_b; p_k <= i_k; p_state <= state;
    p_first <= (i_k == '0);
    p_last <= (i_k == IDX_W'(N - 1));
    if (rst) p_go <= 1'b0; else p_go <= go;
  end

  always_comb begin
    if (p_state == ROWS) prod = ACC_W'(basis(p_b, p_k) * s_rd);
    else                 prod = ACC_W'(basis(p_a, p_k) * r_rd);
  end

  always_ff @(posedge clk) begin
    acc <= p_first ? prod : acc + prod;
    q_a <= p_a; q_b <= p_b; q_state <= p_state;
    q_last <= p_last;
    if (rst) q_go <= 1'b0; else q_go <= p_go;
  end

  assign sum = acc;
  assign mag = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
  assign qv = mag >> (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (q_go && q_last && q_state == ROWS) row_mem[{q_a, q_b}] <= ROW_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= q_go && q_last && (q_state == COLS);
    end
    freq_row <= q_a;
    freq_col <= q_b;
    block_last <= (q_a == IDX_W'(N - 1)) && (q_b == IDX_W'(N - 1));
    if (sum[ACC_W-1]) coefficient <= (qv > 1024) ? -COEF_W'(1024) : COEF_W'(-qv);
    else              coefficient <= (qv > 1023) ? COEF_W'(1023) : COEF_W'(qv);
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    block_done |-> state == IDLE) else $error("block done while busy");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == IDLE) else $error("write during compute");
  a_out_cols: assert property (@(posedge clk) disable iff (rst)
    valid |-> state == COLS || state == DRAIN) else $error("output outside column pass");

endmodule
`default_nettype wire

// ----- sv/luma_block_dct_8x8_unit.sv -----
// Channel  | Handshake      | Payload
// request  | start / busy   | pixel_value[7:0]
// result   | valid (strobe) | coefficient[10:0], freq_row, freq_col, block_last
// 63 samples take one cycle each; the 64th starts 1024 multiply-accumulates on one
// shared multiplier (512 row pass, 512 column pass) and then a drain. busy rises the
// cycle after the 64th request and stays high until the last coefficient has been
// presented. rst is synchronous, active high; column-pass results appear one at a
// time, each for one cycle; the receiver cannot stall.
`default_nettype none
module luma_block_dct_8x8_unit import ldct_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [7:0]        pixel_value,
  output logic                   busy,
  output logic                   valid,
  output logic signed [COEF_W-1:0] coefficient,
  output logic [IDX_W-1:0]       freq_row,
  output logic [IDX_W-1:0]       freq_col,
  output logic                   block_last
);

  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic                      block_done;

  ldct_front u_front (
    .clk, .rst, .start, .pixel_value, .busy,
    .wr_en, .wr_addr, .wr_data, .block_done
  );

  ldct_back u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .block_done,
    .busy, .valid, .coefficient, .freq_row, .freq_col, .block_last
  );

endmodule
`default_nettype wire
